[rtl/sla_pkg.sv]
// Shared types and constants for the serial line assembler with mailbox.
package sla_pkg;

    localparam int LINE_CAPACITY_DEF = 64;
    localparam int CHAR_W            = 8;
    localparam int BANK_AW           = 6;
    localparam int STORE_AW          = BANK_AW + 1;
    localparam int STORE_DEPTH       = 1 << STORE_AW;
    localparam int RUN_W             = 6;
    localparam int CNT16_W           = 16;

    localparam logic [RUN_W-1:0]  RUN_LIMIT = 6'd63;
    localparam logic [CHAR_W-1:0] CHAR_CR   = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_LF   = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_NUL  = 8'h00;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TAKE = 1'b1;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_CHAR   = 2'd1;
    localparam logic [1:0] KIND_NONE   = 2'd2;

    // Classified command handed from the front to the back
    typedef struct packed {
        logic              is_take;
        logic              is_eol;
        logic              is_zero;
        logic [CHAR_W-1:0] data;
    } cmd_t;

endpackage

[rtl/sla_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/sla_front.sv]
// Input side: accepts items, classifies them and queues them for the back end.
module sla_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [sla_pkg::CHAR_W-1:0]  s_data,
    input  logic                        s_op,
    output logic                        q_valid,
    input  logic                        q_ready,
    output sla_pkg::cmd_t               q_cmd
);

    sla_pkg::cmd_t slot_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    fill_reg,   fill_next;
    sla_pkg::cmd_t in_cmd;
    logic          push, pop;

    always_comb begin
        in_cmd.is_take = (s_op == sla_pkg::OP_TAKE);
        in_cmd.is_eol  = (s_op == sla_pkg::OP_BYTE) &&
                         (s_data == sla_pkg::CHAR_CR || s_data == sla_pkg::CHAR_LF);
        in_cmd.is_zero = (s_data == sla_pkg::CHAR_NUL);
        in_cmd.data    = s_data;
    end

    // hold off input while reset is applied
    assign s_ready = aresetn && (fill_reg != 2'd2);
    assign q_valid = (fill_reg != 2'd0);
    assign q_cmd   = slot_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        priority if (push && !pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 2'd1;
        end else begin
            fill_next = fill_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

[rtl/sla_back.sv]
// Back end: line assembly, mailbox, counters and result streaming.
module sla_back #(
    parameter int LINE_CAPACITY = sla_pkg::LINE_CAPACITY_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  sla_pkg::cmd_t                 q_cmd,
    output logic                          ram_we,
    output logic [sla_pkg::STORE_AW-1:0]  ram_waddr,
    output logic [sla_pkg::CHAR_W-1:0]    ram_wdata,
    output logic [sla_pkg::STORE_AW-1:0]  ram_raddr,
    input  logic [sla_pkg::CHAR_W-1:0]    ram_rdata,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_kind,
    output logic [sla_pkg::CHAR_W-1:0]    m_char,
    output logic                          m_last,
    output logic                          m_full,
    output logic [sla_pkg::CNT16_W-1:0]   m_dropped,
    output logic [sla_pkg::CNT16_W-1:0]   m_overflow,
    output logic [sla_pkg::RUN_W-1:0]     m_tlen
);

    localparam int CNT_W = $clog2(LINE_CAPACITY);
    localparam logic [CNT_W-1:0] CAP_M1 = CNT_W'(LINE_CAPACITY - 1);

    typedef enum logic [1:0] {ST_IDLE, ST_FETCH, ST_STREAM} state_t;

    state_t                       state_reg,    state_next;
    logic                         bank_reg,     bank_next;
    logic [CNT_W-1:0]             count_reg,    count_next;
    logic [CNT_W-1:0]             tlen_reg,     tlen_next;
    logic                         zero_reg,     zero_next;
    logic [CNT_W-1:0]             plen_reg,     plen_next;
    logic                         pend_reg,     pend_next;
    logic [sla_pkg::CNT16_W-1:0]  dropped_reg,  dropped_next;
    logic [sla_pkg::CNT16_W-1:0]  overflow_reg, overflow_next;
    logic [sla_pkg::RUN_W-1:0]    run_reg,      run_next;
    logic [sla_pkg::RUN_W-1:0]    idx_reg,      idx_next;

    logic                         out_valid_reg, out_valid_next;
    logic [1:0]                   out_kind_reg,  out_kind_next;
    logic [sla_pkg::CHAR_W-1:0]   out_char_reg,  out_char_next;
    logic                         out_last_reg,  out_last_next;
    logic                         out_full_reg,  out_full_next;
    logic [sla_pkg::CNT16_W-1:0]  out_drop_reg,  out_drop_next;
    logic [sla_pkg::CNT16_W-1:0]  out_ovf_reg,   out_ovf_next;
    logic [sla_pkg::RUN_W-1:0]    out_tlen_reg,  out_tlen_next;

    logic                         out_free;
    logic [sla_pkg::BANK_AW-1:0]  wr_off;
    logic [sla_pkg::STORE_AW-1:0] plen_ext;
    logic [sla_pkg::RUN_W-1:0]    run_len;
    logic                         run_end;

    assign out_free  = !out_valid_reg || m_ready;
    assign wr_off    = sla_pkg::BANK_AW'(count_reg);
    assign plen_ext  = sla_pkg::STORE_AW'(plen_reg);
    assign run_len   = (plen_ext > sla_pkg::STORE_AW'(sla_pkg::RUN_LIMIT)) ?
                       sla_pkg::RUN_LIMIT : plen_ext[sla_pkg::RUN_W-1:0];
    assign run_end   = (idx_reg + 6'd1 == run_reg);

    assign ram_waddr = {bank_reg, wr_off};
    assign ram_wdata = q_cmd.data;
    // the waiting line always sits in the bank not being filled
    assign ram_raddr = {~bank_reg, idx_reg};

    always_comb begin
        state_next     = state_reg;
        bank_next      = bank_reg;
        count_next     = count_reg;
        tlen_next      = tlen_reg;
        zero_next      = zero_reg;
        plen_next      = plen_reg;
        pend_next      = pend_reg;
        dropped_next   = dropped_reg;
        overflow_next  = overflow_reg;
        run_next       = run_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_kind_next  = out_kind_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_full_next  = out_full_reg;
        out_drop_next  = out_drop_reg;
        out_ovf_next   = out_ovf_reg;
        out_tlen_next  = out_tlen_reg;
        q_ready        = 1'b0;
        ram_we         = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid && out_free) begin
                    q_ready        = 1'b1;
                    out_valid_next = 1'b1;
                    out_char_next  = sla_pkg::CHAR_NUL;
                    out_last_next  = 1'b1;
                    out_tlen_next  = '0;
                    if (!q_cmd.is_take) begin
                        out_kind_next = sla_pkg::KIND_STATUS;
                        priority if (q_cmd.is_eol) begin
                            if (count_reg != '0) begin
                                if (!pend_reg) begin
                                    pend_next = 1'b1;
                                    plen_next = tlen_reg;
                                    bank_next = ~bank_reg;
                                end else begin
                                    dropped_next = dropped_reg + 16'd1;
                                end
                                count_next = '0;
                                tlen_next  = '0;
                                zero_next  = 1'b0;
                            end
                        end else if (count_reg < CAP_M1) begin
                            ram_we     = 1'b1;
                            count_next = CNT_W'(count_reg + 1'b1);
                            if (q_cmd.is_zero) begin
                                zero_next = 1'b1;
                            end else if (!zero_reg) begin
                                tlen_next = CNT_W'(tlen_reg + 1'b1);
                            end
                        end else begin
                            // line full: drop the byte and start over
                            overflow_next = overflow_reg + 16'd1;
                            count_next    = '0;
                            tlen_next     = '0;
                            zero_next     = 1'b0;
                        end
                        out_full_next = pend_next;
                        out_drop_next = dropped_next;
                        out_ovf_next  = overflow_next;
                    end else begin
                        out_full_next = 1'b0;
                        out_drop_next = dropped_reg;
                        out_ovf_next  = overflow_reg;
                        if (!pend_reg) begin
                            out_kind_next = sla_pkg::KIND_NONE;
                        end else begin
                            pend_next     = 1'b0;
                            out_kind_next = sla_pkg::KIND_CHAR;
                            if (run_len != '0) begin
                                // hold the output empty until the first char is read
                                out_valid_next = 1'b0;
                                run_next       = run_len;
                                idx_next       = '0;
                                state_next     = ST_FETCH;
                            end
                        end
                    end
                end
            end
            ST_FETCH: begin
                state_next = ST_STREAM;
            end
            ST_STREAM: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = sla_pkg::KIND_CHAR;
                    out_char_next  = ram_rdata;
                    out_last_next  = run_end;
                    out_full_next  = 1'b0;
                    out_drop_next  = dropped_reg;
                    out_ovf_next   = overflow_reg;
                    out_tlen_next  = run_reg;
                    if (run_end) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + 6'd1;
                        state_next = ST_FETCH;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            bank_reg      <= 1'b0;
            count_reg     <= '0;
            tlen_reg      <= '0;
            zero_reg      <= 1'b0;
            plen_reg      <= '0;
            pend_reg      <= 1'b0;
            dropped_reg   <= '0;
            overflow_reg  <= '0;
            run_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            bank_reg      <= bank_next;
            count_reg     <= count_next;
            tlen_reg      <= tlen_next;
            zero_reg      <= zero_next;
            plen_reg      <= plen_next;
            pend_reg      <= pend_next;
            dropped_reg   <= dropped_next;
            overflow_reg  <= overflow_next;
            run_reg       <= run_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
        out_kind_reg <= out_kind_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        out_full_reg <= out_full_next;
        out_drop_reg <= out_drop_next;
        out_ovf_reg  <= out_ovf_next;
        out_tlen_reg <= out_tlen_next;
    end

    assign m_valid    = out_valid_reg;
    assign m_kind     = out_kind_reg;
    assign m_char     = out_char_reg;
    assign m_last     = out_last_reg;
    assign m_full     = out_full_reg;
    assign m_dropped  = out_drop_reg;
    assign m_overflow = out_ovf_reg;
    assign m_tlen     = out_tlen_reg;

endmodule

[rtl/serial_line_assembler_mailbox.sv]
// A byte or empty-mailbox item gives its result through the input queue and the output register.
// One byte item per cycle while the output is free and no take is streaming; a take
// reads each char in FETCH then STREAM (registered line store read) before the next item is taken.
// A 2-entry queue separates input acceptance from execution.
// Reset (aresetn low, synchronous) clears counters, mailbox and queue; the line
// store is not cleared and is only read where written.
module serial_line_assembler_mailbox #(
    parameter int LINE_CAPACITY = sla_pkg::LINE_CAPACITY_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]  s_axis_tuser,   // [0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] line_char, [8] mailbox_full, [24:9] dropped_lines,
    // [40:25] overflow_events, [46:41] taken_length, [47] zero
    output logic [47:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast
);

    logic                           q_valid;
    logic                           q_ready;
    sla_pkg::cmd_t                  q_cmd;
    logic                           ram_we;
    logic [sla_pkg::STORE_AW-1:0]   ram_waddr;
    logic [sla_pkg::CHAR_W-1:0]     ram_wdata;
    logic [sla_pkg::STORE_AW-1:0]   ram_raddr;
    logic [sla_pkg::CHAR_W-1:0]     ram_rdata;
    logic [sla_pkg::CHAR_W-1:0]     m_char;
    logic                           m_full;
    logic [sla_pkg::CNT16_W-1:0]    m_dropped;
    logic [sla_pkg::CNT16_W-1:0]    m_overflow;
    logic [sla_pkg::RUN_W-1:0]      m_tlen;

    sla_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_data  (s_axis_tdata),
        .s_op    (s_axis_tuser[0]),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_cmd   (q_cmd)
    );

    sla_ram #(
        .WIDTH (sla_pkg::CHAR_W),
        .DEPTH (sla_pkg::STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sla_back #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_cmd      (q_cmd),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_kind     (m_axis_tuser),
        .m_char     (m_char),
        .m_last     (m_axis_tlast),
        .m_full     (m_full),
        .m_dropped  (m_dropped),
        .m_overflow (m_overflow),
        .m_tlen     (m_tlen)
    );

    assign m_axis_tdata = {1'b0, m_tlen, m_overflow, m_dropped, m_full, m_char};

`ifndef ASSERT_OFF
    a_char_mailbox_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == sla_pkg::KIND_CHAR |-> !m_axis_tdata[8])
        else $error("mailbox shown full on a taken line character");

    a_single_result_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == sla_pkg::KIND_STATUS ||
                          m_axis_tuser == sla_pkg::KIND_NONE) |-> m_axis_tlast)
        else $error("single-result item without last");

    a_no_length_off_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser != sla_pkg::KIND_CHAR |-> m_axis_tdata[46:41] == 6'd0)
        else $error("taken length outside a line run");
`endif

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the serial line assembler with its one-slot mailbox.
`timescale 1ns / 1ps

module tb_top;

    localparam int LINE_CAP     = sla_pkg::LINE_CAPACITY_DEF;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 12;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  line_char;
        logic        last;
        logic        mbox_full;
        logic [15:0] dropped;
        logic [15:0] overflows;
        logic [5:0]  taken_len;
    } line_result_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic [0:0]  s_axis_tuser  = sla_pkg::OP_BYTE;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // Sender and receiver idle chances in percent, plus a long receiver hold-off
    int unsigned tx_idle_pct    = 0;
    int unsigned rx_idle_pct    = 0;
    int unsigned rx_hold_cycles = 0;
    int unsigned rx_items_sent  = 0;
    int unsigned fail_count     = 0;
    int unsigned cycle_count    = 0;

    // Shadow of the assembler: line banks, gathering state, mailbox and counters
    logic [7:0]  shadow_store [sla_pkg::STORE_DEPTH];
    logic        gather_bank    = 1'b0;
    int unsigned gather_count   = 0;
    int unsigned gather_textlen = 0;
    bit          gather_zero    = 1'b0;
    int unsigned mbox_len       = 0;
    bit          mbox_valid     = 1'b0;
    logic [15:0] dropped_cnt    = 16'd0;
    logic [15:0] overflow_cnt   = 16'd0;

    line_result_t owed_results[$];

    serial_line_assembler_mailbox #(
        .LINE_CAPACITY(LINE_CAP)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (rx_hold_cycles > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold_cycles--;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic void owe_result(logic [1:0] kind, logic [7:0] ch, logic last,
                                       logic [5:0] tlen);
        line_result_t r;
        r.kind      = kind;
        r.line_char = ch;
        r.last      = last;
        r.mbox_full = mbox_valid;
        r.dropped   = dropped_cnt;
        r.overflows = overflow_cnt;
        r.taken_len = tlen;
        owed_results.push_back(r);
    endfunction

    function automatic void restart_gather();
        gather_count   = 0;
        gather_textlen = 0;
        gather_zero    = 1'b0;
    endfunction

    // Advance the shadow by one accepted item and queue the results it owes
    function automatic void track_rx_item(logic op, logic [7:0] b);
        int unsigned n;
        logic        rd_bank;
        if (op == sla_pkg::OP_BYTE) begin
            if (b == sla_pkg::CHAR_CR || b == sla_pkg::CHAR_LF) begin
                if (gather_count > 0) begin
                    if (!mbox_valid) begin
                        mbox_valid  = 1'b1;
                        mbox_len    = gather_textlen;
                        gather_bank = ~gather_bank;
                    end else begin
                        dropped_cnt = dropped_cnt + 16'd1;
                    end
                    restart_gather();
                end
            end else if (gather_count < LINE_CAP - 1) begin
                shadow_store[{gather_bank, 6'(gather_count)}] = b;
                gather_count++;
                if (b == sla_pkg::CHAR_NUL)
                    gather_zero = 1'b1;
                else if (!gather_zero)
                    gather_textlen++;
            end else begin
                // line full: drop the byte and start over
                overflow_cnt = overflow_cnt + 16'd1;
                restart_gather();
            end
            owe_result(sla_pkg::KIND_STATUS, 8'h00, 1'b1, 6'd0);
        end else if (!mbox_valid) begin
            owe_result(sla_pkg::KIND_NONE, 8'h00, 1'b1, 6'd0);
        end else begin
            mbox_valid = 1'b0;
            n = (mbox_len > sla_pkg::RUN_LIMIT) ? sla_pkg::RUN_LIMIT : mbox_len;
            rd_bank = ~gather_bank;
            if (n == 0) begin
                owe_result(sla_pkg::KIND_CHAR, 8'h00, 1'b1, 6'd0);
            end else begin
                for (int unsigned i = 0; i < n; i++)
                    owe_result(sla_pkg::KIND_CHAR, shadow_store[{rd_bank, 6'(i)}],
                               (i + 1 == n), 6'(n));
            end
        end
    endfunction

    function automatic void check_field(string name, int unsigned expv, int unsigned actv);
        if (expv != actv) begin
            $error("%s mismatch: expected %0d, got %0d", name, expv, actv);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        line_result_t e;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (owed_results.size() == 0) begin
                $error("unexpected result item: kind %0d char %0d", m_axis_tuser,
                       m_axis_tdata[7:0]);
                fail_count++;
            end else begin
                e = owed_results.pop_front();
                check_field("kind", e.kind, m_axis_tuser);
                check_field("line_char", e.line_char, m_axis_tdata[7:0]);
                check_field("last", e.last, m_axis_tlast);
                check_field("mailbox_full", e.mbox_full, m_axis_tdata[8]);
                check_field("dropped_lines", e.dropped, m_axis_tdata[24:9]);
                check_field("overflow_events", e.overflows, m_axis_tdata[40:25]);
                check_field("taken_length", e.taken_len, m_axis_tdata[46:41]);
                check_field("tdata_pad", 0, m_axis_tdata[47]);
            end
        end
    end

    // Called and returns at a falling edge; valid stays high into the next item
    task automatic push_rx_item(logic op, logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= b;
        do
            @(posedge aclk);
        while (!s_axis_tready);
        track_rx_item(op, b);
        rx_items_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [7:0] text_byte(bit allow_zero);
        logic [7:0] b;
        if (allow_zero && $urandom_range(15) == 0)
            return sla_pkg::CHAR_NUL;
        do
            b = 8'($urandom_range(1, 255));
        while (b == sla_pkg::CHAR_CR || b == sla_pkg::CHAR_LF);
        return b;
    endfunction

    task automatic send_random_line(int unsigned len, bit allow_zero);
        for (int unsigned i = 0; i < len; i++)
            push_rx_item(sla_pkg::OP_BYTE, text_byte(allow_zero));
        push_rx_item(sla_pkg::OP_BYTE, $urandom_range(1) ? sla_pkg::CHAR_CR : sla_pkg::CHAR_LF);
    endtask

    task automatic test_directed_cases();
        push_rx_item(sla_pkg::OP_TAKE, 8'h00);      // empty mailbox
        push_rx_item(sla_pkg::OP_BYTE, sla_pkg::CHAR_CR);    // nothing gathered: ignore
        push_rx_item(sla_pkg::OP_BYTE, sla_pkg::CHAR_LF);
        push_rx_item(sla_pkg::OP_BYTE, 8'h48);
        push_rx_item(sla_pkg::OP_BYTE, 8'hFF);
        push_rx_item(sla_pkg::OP_BYTE, 8'h01);
        push_rx_item(sla_pkg::OP_BYTE, sla_pkg::CHAR_CR);
        push_rx_item(sla_pkg::OP_BYTE, 8'h58);      // mailbox full: this line is dropped
        push_rx_item(sla_pkg::OP_BYTE, sla_pkg::CHAR_LF);
        push_rx_item(sla_pkg::OP_TAKE, 8'hFF);      // byte field ignored on a take
        push_rx_item(sla_pkg::OP_TAKE, 8'h00);
        push_rx_item(sla_pkg::OP_BYTE, 8'h41);      // text ends at the zero byte
        push_rx_item(sla_pkg::OP_BYTE, sla_pkg::CHAR_NUL);
        push_rx_item(sla_pkg::OP_BYTE, 8'h42);
        push_rx_item(sla_pkg::OP_BYTE, sla_pkg::CHAR_LF);
        push_rx_item(sla_pkg::OP_TAKE, 8'h00);
        push_rx_item(sla_pkg::OP_BYTE, sla_pkg::CHAR_NUL);   // non-empty line, empty text
        push_rx_item(sla_pkg::OP_BYTE, sla_pkg::CHAR_CR);
        push_rx_item(sla_pkg::OP_TAKE, 8'h80);
        push_rx_item(sla_pkg::OP_BYTE, 8'h7F);
        push_rx_item(sla_pkg::OP_BYTE, 8'h80);
        push_rx_item(sla_pkg::OP_BYTE, sla_pkg::CHAR_CR);
        push_rx_item(sla_pkg::OP_TAKE, 8'h00);
        wait_drain();
    endtask

    task automatic test_line_full();
        for (int i = 0; i < LINE_CAP - 1; i++)
            push_rx_item(sla_pkg::OP_BYTE, 8'($urandom_range(8'h20, 8'h7E)));
        push_rx_item(sla_pkg::OP_BYTE, 8'h5A);      // one too many: overflow and restart
        push_rx_item(sla_pkg::OP_BYTE, 8'h31);
        push_rx_item(sla_pkg::OP_BYTE, sla_pkg::CHAR_CR);
        push_rx_item(sla_pkg::OP_TAKE, 8'h00);
        wait_drain();
    endtask

    task automatic test_random_traffic(int unsigned n_items);
        int unsigned target;
        int unsigned pick;
        int unsigned len;
        target = rx_items_sent + n_items;
        while (rx_items_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                len = $urandom_range(1, 5);
                send_random_line(len, 1'b1);
                if ($urandom_range(9) < 6)
                    push_rx_item(sla_pkg::OP_TAKE, 8'($urandom_range(255)));
            end else if (pick < 85) begin
                push_rx_item(sla_pkg::OP_TAKE, 8'($urandom_range(255)));
            end else begin
                push_rx_item(1'($urandom_range(1)), 8'($urandom_range(255)));
            end
        end
        wait_drain();
    endtask

    task automatic test_backpressure();
        tx_idle_pct    = 0;
        rx_hold_cycles = 200;
        send_random_line(4, 1'b0);
        push_rx_item(sla_pkg::OP_TAKE, 8'h00);
        // pause the sender until everything owed has come out
        wait_drain();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        tx_idle_pct = 11;
        rx_idle_pct = 56;
        test_directed_cases();
        test_line_full();
        test_random_traffic(6);

        tx_idle_pct = 56;
        rx_idle_pct = 11;
        test_random_traffic(6);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_traffic(6);
        test_backpressure();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && owed_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[filelist.f]
rtl/sla_pkg.sv
rtl/sla_ram.sv
rtl/sla_front.sv
rtl/sla_back.sv
rtl/serial_line_assembler_mailbox.sv
tb/tb_top.sv
